### rtl/echo_detection_slot_table_macros.svh
// Assertion helpers used by esdt_scan.
`ifndef ECHO_DETECTION_SLOT_TABLE_MACROS_SVH
`define ECHO_DETECTION_SLOT_TABLE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ESDT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that implies a consequence in the cycle after it.
`define ESDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/esdt_pkg.sv
package esdt_pkg;

  // Default slot count
  localparam int SLOTS_DEFAULT = 10;

  // Field widths
  localparam int ECHO_W  = 15;
  localparam int TIME_W  = 32;
  localparam int DIST_W  = 19;
  localparam int MAXCM_W = 9;
  localparam int FADE_W  = 16;
  localparam int CFG_W   = 16;

  // Arithmetic constants
  localparam int MILLI_CM_PER_US = 17;
  localparam int MILLI_PER_CM    = 1000;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Register reset values
  localparam logic [MAXCM_W-1:0] MAX_CM_RESET = 9'd200;
  localparam logic [FADE_W-1:0]  FADE_RESET   = 16'd3000;

  // Register indexes
  localparam logic REG_MAX_DISTANCE = 1'b0;
  localparam logic REG_FADE         = 1'b1;

  typedef struct packed {
    logic [ECHO_W-1:0] echo_us;
    logic [TIME_W-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_milli_cm;
    logic              accepted;
    logic [3:0]        slot_used;
    logic              evicted;
    logic [9:0]        expired_mask;
    logic [3:0]        active_count;
  } result_t;

  typedef struct packed {
    logic [MAXCM_W-1:0] max_distance_cm;
    logic [FADE_W-1:0]  fade_ms;
  } cfg_t;

  // One slot of the table
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] stamp;
    logic [ECHO_W-1:0] echo;
  } entry_t;

  // Chain control from the scanner
  typedef struct packed {
    logic shift;
    logic write;
  } ctl_t;

endpackage

### rtl/esdt_cell.sv
module esdt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  esdt_pkg::entry_t shift_in,
  input  logic            wr,
  input  esdt_pkg::entry_t wr_data,
  output esdt_pkg::entry_t q
);

  // Valid flag cleared at reset; payload undefined until written
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (wr) begin
      q.valid <= wr_data.valid;
    end else if (shift) begin
      q.valid <= shift_in.valid;
    end
    if (wr) begin
      q.stamp <= wr_data.stamp;
      q.echo  <= wr_data.echo;
    end else if (shift) begin
      q.stamp <= shift_in.stamp;
      q.echo  <= shift_in.echo;
    end
  end

endmodule

### rtl/esdt_scan.sv
`include "echo_detection_slot_table_macros.svh"

module esdt_scan #(
  parameter int SLOTS = esdt_pkg::SLOTS_DEFAULT,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  esdt_pkg::cmd_t    cmd,
  input  esdt_pkg::cfg_t    cfg,
  input  esdt_pkg::entry_t  head,
  output esdt_pkg::ctl_t    ctl,
  output esdt_pkg::entry_t  tail,
  output logic [IDX_W-1:0]  wr_idx,
  output esdt_pkg::entry_t  wr_data,
  output esdt_pkg::result_t result,
  output logic              done
);

  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0] state;

  // Latched word
  logic [esdt_pkg::ECHO_W-1:0] echo_r;
  logic [esdt_pkg::TIME_W-1:0] now_r;
  logic [esdt_pkg::DIST_W-1:0] dist_r;
  logic                        acc_r;

  // Scan token
  logic [IDX_W-1:0]            cnt;
  logic                        free_found;
  logic [IDX_W-1:0]            free_idx;
  logic                        min_have;
  logic [IDX_W-1:0]            min_idx;
  logic [esdt_pkg::TIME_W-1:0] min_time;
  logic                        min_surv;
  logic [SLOTS-1:0]            exp_mask;
  logic [CNT_W-1:0]            surv_cnt;

  // Acceptance test on the incoming word
  logic [esdt_pkg::DIST_W:0]   dist_full;
  logic [esdt_pkg::DIST_W-1:0] limit;
  logic                        acc_in;
  logic                        take;

  assign take      = start && !busy;
  assign dist_full = (esdt_pkg::DIST_W + 1)'(cmd.echo_us)
                     * (esdt_pkg::DIST_W + 1)'(esdt_pkg::MILLI_CM_PER_US);
  assign limit     = esdt_pkg::DIST_W'(cfg.max_distance_cm)
                     * esdt_pkg::DIST_W'(esdt_pkg::MILLI_PER_CM);
  assign acc_in    = (cmd.echo_us != '0)
                     && (dist_full < (esdt_pkg::DIST_W + 1)'(limit));

  // Head-of-chain check
  logic [esdt_pkg::TIME_W-1:0] age;
  logic                        expire;
  logic                        surv;
  logic                        newer_min;

  assign age       = now_r - head.stamp;
  assign expire    = head.valid && (age > esdt_pkg::TIME_W'(cfg.fade_ms));
  assign surv      = head.valid && !expire;
  assign newer_min = head.valid && (!min_have || (head.stamp < min_time));

  assign tail = '{valid: surv, stamp: head.stamp, echo: head.echo};

  // Chain control and slot write
  logic [IDX_W-1:0] pick;

  assign pick      = free_found ? free_idx : min_idx;
  assign busy      = (state != ST_IDLE);
  assign ctl.shift = (state == ST_SCAN);
  assign ctl.write = (state == ST_WRITE) && acc_r;
  assign wr_idx    = pick;
  assign wr_data   = '{valid: 1'b1, stamp: now_r, echo: echo_r};

  // Result assembly
  esdt_pkg::result_t res_next;
  logic [SLOTS-1:0]  pick_mask;
  logic [SLOTS+9:0]  mask_ext;
  logic [CNT_W-1:0]  cnt_final;
  logic [CNT_W+3:0]  cnt_ext;
  logic [IDX_W+3:0]  pick_ext;

  always_comb begin
    pick_mask = acc_r ? (SLOTS'(1) << pick) : '0;
    mask_ext  = {10'b0, exp_mask & ~pick_mask};
    cnt_final = surv_cnt + CNT_W'(acc_r)
                - CNT_W'(acc_r && !free_found && min_surv);
    cnt_ext   = (CNT_W + 4)'(cnt_final);
    pick_ext  = (IDX_W + 4)'(pick);
    res_next.distance_milli_cm = dist_r;
    res_next.accepted          = acc_r;
    res_next.slot_used         = acc_r ? pick_ext[3:0] : 4'd0;
    res_next.evicted           = acc_r && !free_found;
    res_next.expired_mask      = mask_ext[9:0];
    res_next.active_count      = (cnt_ext > (CNT_W + 4)'(15)) ? 4'hF : cnt_ext[3:0];
  end

  // Sequencer: accept, scan the chain once around, then write
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt == IDX_W'(SLOTS - 1)) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Token and word registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && take) begin
      echo_r     <= cmd.echo_us;
      now_r      <= cmd.now_ms;
      acc_r      <= acc_in;
      dist_r     <= dist_full[esdt_pkg::DIST_W] ? esdt_pkg::DIST_MAX
                                                : dist_full[esdt_pkg::DIST_W-1:0];
      cnt        <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
      min_have   <= 1'b0;
      min_idx    <= '0;
      min_time   <= '0;
      min_surv   <= 1'b0;
      exp_mask   <= '0;
      surv_cnt   <= '0;
    end else if (state == ST_SCAN) begin
      cnt           <= cnt + IDX_W'(1);
      exp_mask[cnt] <= expire;
      surv_cnt      <= surv_cnt + CNT_W'(surv);
      if (!head.valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cnt;
      end
      if (newer_min) begin
        min_have <= 1'b1;
        min_idx  <= cnt;
        min_time <= head.stamp;
        min_surv <= surv;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      result <= res_next;
    end
  end

  `ESDT_ASSERT_ALWAYS(a_done_after_write, !done || $past(state == ST_WRITE), "done without write")
  `ESDT_ASSERT_NEXT(a_take_scans, take, state == ST_SCAN, "accepted word did not start a scan")
  `ESDT_ASSERT_ALWAYS(a_count_fits, !done || (result.active_count <= SLOTS), "count above slots")
  `ESDT_ASSERT_ALWAYS(a_evict_needs_accept, !done || !result.evicted || result.accepted, "evict without accept")

endmodule

### rtl/echo_detection_slot_table.sv
// Echo slot table.
// Command channel: drive cmd (echo width in us, time in ms) and raise start;
// the word is taken at a clock edge where start is high and busy is low.
// busy stays high while the word is processed.
// Result channel: result is valid for exactly one cycle while done is high;
// the receiver cannot stall, so it must capture the word in that cycle.
// Sequence: after the accepting edge the entries rotate once around per word
// past a single check unit at the head, then the chosen slot is written
// directly and done rises. No new word is taken while busy is high; a new
// word can be taken in the cycle done is high.
// Configuration: cfg_we with cfg_index and cfg_data writes a register
// (index 0 distance limit in cm, index 1 fade time in ms); write
// only while busy is low and no result is pending.
// Reset (rst, synchronous): all slots go inactive, registers return to
// 200 cm and 3000 ms, busy and done drop.
module echo_detection_slot_table #(
  parameter int SLOTS = esdt_pkg::SLOTS_DEFAULT,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  esdt_pkg::cmd_t             cmd,
  output esdt_pkg::result_t          result,
  output logic                       done,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [esdt_pkg::CFG_W-1:0] cfg_data
);

  esdt_pkg::cfg_t   cfg;
  esdt_pkg::ctl_t   ctl;
  esdt_pkg::entry_t tail;
  esdt_pkg::entry_t wr_data;
  logic [IDX_W-1:0] wr_idx;
  esdt_pkg::entry_t q [SLOTS];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_distance_cm <= esdt_pkg::MAX_CM_RESET;
      cfg.fade_ms         <= esdt_pkg::FADE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        esdt_pkg::REG_MAX_DISTANCE: cfg.max_distance_cm <= cfg_data[esdt_pkg::MAXCM_W-1:0];
        esdt_pkg::REG_FADE:         cfg.fade_ms         <= cfg_data[esdt_pkg::FADE_W-1:0];
        default: ;
      endcase
    end
  end

  // Slot chain: entries move toward cell 0, the head re-enters at the tail
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    esdt_pkg::entry_t nbr;
    if (i == SLOTS - 1) begin : g_last
      assign nbr = tail;
    end else begin : g_mid
      assign nbr = q[i+1];
    end
    esdt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (ctl.shift),
      .shift_in (nbr),
      .wr       (ctl.write && (wr_idx == IDX_W'(i))),
      .wr_data  (wr_data),
      .q        (q[i])
    );
  end

  esdt_scan #(.SLOTS(SLOTS)) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .cfg     (cfg),
    .head    (q[0]),
    .ctl     (ctl),
    .tail    (tail),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .result  (result),
    .done    (done)
  );

endmodule

### tb/echo_detection_slot_table_tb.sv
module echo_detection_slot_table_tb;
  import esdt_pkg::*;

  localparam int SLOTS = SLOTS_DEFAULT;
  localparam int SETTLE_CYCLES = SLOTS + 6;
  localparam int DIR_ROWS = 25;
  localparam result_t ZERO_RESULT = '0;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

  // One line of the directed table: either a command word or a register write
  typedef struct packed {
    row_kind_e         kind;
    logic              cfg_reg;
    logic [CFG_W-1:0]  cfg_val;
    logic [ECHO_W-1:0] echo;
    logic [TIME_W-1:0] now;
    logic              known;
    result_t           exp;
  } step_row_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  cmd_t             cmd;
  result_t          result;
  logic             done;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // Shadow of the block's table and registers
  logic               slot_live [SLOTS];
  logic [TIME_W-1:0]  slot_stamp [SLOTS];
  logic [MAXCM_W-1:0] max_cm_mirror;
  logic [FADE_W-1:0]  fade_mirror;
  logic [TIME_W-1:0]  clock_ms;

  result_t   pending_results [$];
  int        mismatch_count;
  step_row_t dir_rows [DIR_ROWS];
  result_t   want;
  logic      bad;

  echo_detection_slot_table uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .result    (result),
    .done      (done),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("echo_detection_slot_table verification failed");
    $finish;
  end

  // Place an echo in the table, age out stale slots, and build the result word
  task automatic update_slot_table(input cmd_t w, output result_t r);
    int unsigned dist_val;
    int unsigned limit;
    int unsigned count;
    int pick;
    logic [TIME_W-1:0] age;
    dist_val = int'(w.echo_us) * MILLI_CM_PER_US;
    limit = int'(max_cm_mirror) * MILLI_PER_CM;
    r = '0;
    if (w.echo_us != 0 && dist_val < limit) begin
      pick = -1;
      for (int i = 0; i < SLOTS; i++)
        if (!slot_live[i] && pick < 0) pick = i;
      // table full: oldest raw stamp goes, lowest index wins a tie
      if (pick < 0) begin
        pick = 0;
        for (int i = 1; i < SLOTS; i++)
          if (slot_stamp[i] < slot_stamp[pick]) pick = i;
        r.evicted = 1'b1;
      end
      slot_live[pick] = 1'b1;
      slot_stamp[pick] = w.now_ms;
      r.accepted = 1'b1;
      r.slot_used = 4'(pick);
    end
    count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i]) begin
        age = w.now_ms - slot_stamp[i];
        if (age > TIME_W'(fade_mirror)) begin
          slot_live[i] = 1'b0;
          if (i < 10) r.expired_mask[i] = 1'b1;
        end
      end
      if (slot_live[i]) count++;
    end
    r.active_count = (count > 15) ? 4'd15 : 4'(count);
    r.distance_milli_cm = (dist_val > DIST_MAX) ? DIST_MAX : DIST_W'(dist_val);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input cmd_t w, input logic use_typed, input result_t typed);
    result_t pred;
    start <= 1'b1;
    cmd <= w;
    do @(posedge clk); while (busy);
    update_slot_table(w, pred);
    pending_results.push_back(use_typed ? typed : pred);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Hold off until every expected word is back, optionally let the block settle
  task automatic drain_results(input logic settle);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic r, input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    if (r == REG_MAX_DISTANCE) max_cm_mirror = v[MAXCM_W-1:0];
    else fade_mirror = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Random command: mostly in-range echoes on a moving clock, some noise
  task automatic random_word(output cmd_t w);
    int unsigned lim_echo;
    int unsigned fade_u;
    int sel;
    fade_u = fade_mirror;
    lim_echo = (max_cm_mirror == 0) ? 32767 :
               (int'(max_cm_mirror) * MILLI_PER_CM - 1) / MILLI_CM_PER_US;
    sel = $urandom_range(99);
    if (sel < 55) w.echo_us = ECHO_W'($urandom_range(1, lim_echo));
    else if (sel < 65) w.echo_us = ECHO_W'(lim_echo + $urandom_range(0, 2) - 1);
    else if (sel < 75) w.echo_us = '0;
    else w.echo_us = ECHO_W'($urandom_range(0, 32767));
    sel = $urandom_range(99);
    if (sel < 40) clock_ms = clock_ms + $urandom_range(0, fade_u / 8);
    else if (sel < 55) clock_ms = clock_ms;  // same ms: stamp ties
    else if (sel < 80) clock_ms = clock_ms + $urandom_range(0, fade_u + fade_u / 2 + 2);
    else if (sel < 92) clock_ms = clock_ms + fade_u + $urandom_range(1, 100000);
    else clock_ms = $urandom();
    w.now_ms = clock_ms;
  endtask

  // Result checker: every done word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result word with nothing expected: %h", $time, result);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        bad = 1'b0;
        if (result.distance_milli_cm !== want.distance_milli_cm) bad = 1'b1;
        if (result.accepted !== want.accepted) bad = 1'b1;
        if (result.slot_used !== want.slot_used) bad = 1'b1;
        if (result.evicted !== want.evicted) bad = 1'b1;
        if (result.expired_mask !== want.expired_mask) bad = 1'b1;
        if (result.active_count !== want.active_count) bad = 1'b1;
        if (bad) begin
          if (mismatch_count < 10)
            $display("%0t: mismatch exp dist=%0d acc=%0d slot=%0d ev=%0d exp=%03h cnt=%0d",
                     $time, want.distance_milli_cm, want.accepted, want.slot_used,
                     want.evicted, want.expired_mask, want.active_count,
                     "  got dist=%0d acc=%0d slot=%0d ev=%0d exp=%03h cnt=%0d",
                     result.distance_milli_cm, result.accepted, result.slot_used,
                     result.evicted, result.expired_mask, result.active_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cmd_t w;
    int idle_pct;
    int items;
    logic [CFG_W-1:0] cfg_max_val;
    logic [CFG_W-1:0] cfg_fade_val;

    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_index = REG_MAX_DISTANCE;
    cfg_data = '0;
    mismatch_count = 0;
    clock_ms = '0;
    max_cm_mirror = MAX_CM_RESET;
    fade_mirror = FADE_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_stamp[i] = '0;
    end

    // Directed: limits, eviction, expiry, time wrap, zero limit, zero fade
    dir_rows = '{
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd0, 32'd0, 1'b1, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd1, 32'd100, 1'b1,
        '{19'd17, 1'b1, 4'd0, 1'b0, 10'd0, 4'd1}},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd32767, 32'd100, 1'b1,
        '{19'd524287, 1'b0, 4'd0, 1'b0, 10'd0, 4'd1}},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd11764, 32'd200, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd11765, 32'd200, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd5, 32'd300, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd100, 32'd400, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd1000, 32'd500, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd2000, 32'd600, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd4000, 32'd700, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd8000, 32'd800, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd10000, 32'd900, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd11000, 32'd1000, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd500, 32'd1050, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd0, 32'd3250, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd600, 32'hFFFF_FF00, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd700, 32'h0000_0100, 1'b0, ZERO_RESULT},
      '{ROW_CFG, REG_MAX_DISTANCE, 16'd0, 15'd0, 32'd0, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd1, 32'h0000_0200, 1'b0, ZERO_RESULT},
      '{ROW_CFG, REG_MAX_DISTANCE, 16'd511, 15'd0, 32'd0, 1'b0, ZERO_RESULT},
      '{ROW_CFG, REG_FADE, 16'd0, 15'd0, 32'd0, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd30000, 32'h0000_0300, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd30058, 32'h0000_0300, 1'b0, ZERO_RESULT},
      '{ROW_CMD, REG_MAX_DISTANCE, 16'd0, 15'd30059, 32'h0000_0301, 1'b0, ZERO_RESULT},
      '{ROW_CFG, REG_FADE, 16'hFFFF, 15'd0, 32'd0, 1'b0, ZERO_RESULT}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int k = 0; k < DIR_ROWS; k++) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        drain_results(1'b1);
        write_reg(dir_rows[k].cfg_reg, dir_rows[k].cfg_val);
      end else begin
        w.echo_us = dir_rows[k].echo;
        w.now_ms = dir_rows[k].now;
        send_word(w, dir_rows[k].known, dir_rows[k].exp);
      end
    end

    // Random phases: register settings and sender idling vary per phase
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cfg_max_val = 16'd400;
          cfg_fade_val = 16'hFFFF;
        end
        1: begin
          cfg_max_val = 16'd1;
          cfg_fade_val = 16'd0;
        end
        2: begin
          cfg_max_val = 16'd511;
          cfg_fade_val = 16'd1;
        end
        3: begin
          cfg_max_val = 16'd0;
          cfg_fade_val = FADE_RESET;
        end
        default: begin
          // upper data bits beyond the 9-bit limit register are don't-care
          cfg_max_val = CFG_W'($urandom_range(1, 400) | ($urandom_range(0, 127) << 9));
          cfg_fade_val = $urandom_range(1) ? CFG_W'($urandom_range(0, 65535))
                                           : CFG_W'($urandom_range(1, 5000));
        end
      endcase
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 56;
        default: idle_pct = 35;
      endcase
      items = (ph == 3) ? 60 : 380;
      drain_results(1'b1);
      write_reg(REG_MAX_DISTANCE, cfg_max_val);
      write_reg(REG_FADE, cfg_fade_val);
      for (int n = 0; n < items; n++) begin
        if ($urandom_range(99) < idle_pct) idle_gap($urandom_range(1, 16));
        if ($urandom_range(99) == 0) drain_results(1'b0);
        random_word(w);
        send_word(w, 1'b0, ZERO_RESULT);
      end
    end

    drain_results(1'b1);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("echo_detection_slot_table verification clean");
    else
      $display("echo_detection_slot_table verification failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/esdt_pkg.sv
rtl/esdt_cell.sv
rtl/esdt_scan.sv
rtl/echo_detection_slot_table.sv
tb/echo_detection_slot_table_tb.sv
